@@ rtl/core/synced_voltage_to_8bit_quantizer_defines.svh @@
// assertion macros for the synced voltage to 8-bit quantizer checker
// expects clk and arst_n to be visible where a macro is used
`ifndef SYNCED_VOLTAGE_TO_8BIT_QUANTIZER_DEFINES_SVH
`define SYNCED_VOLTAGE_TO_8BIT_QUANTIZER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define SVQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("svq check failed: same cycle");

// next-cycle implication, reset masks the check
`define SVQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("svq check failed: next cycle");

`endif

@@ rtl/core/svq_pkg.sv @@
// shared widths, register and mode codes, and types for the quantizer
// no dependencies
package svq_pkg;

	localparam int SampleWidth   = 16;
	localparam int GainWidth     = 16;
	localparam int OffsetWidth   = 15;
	localparam int OffsetShift   = 14;
	localparam int FracBits      = 25;
	localparam int ProdWidth     = SampleWidth + GainWidth;
	localparam int OffsetExtWidth = OffsetWidth + OffsetShift;
	localparam int XWidth        =
		((ProdWidth > OffsetExtWidth) ? ProdWidth : OffsetExtWidth) + 1;
	localparam int CodeWidth     = 8;
	localparam int ModeWidth     = 2;
	localparam int CfgIndexWidth = 2;
	localparam int CfgDataWidth  = 16;
	localparam int QueueDepth    = 2;
	localparam int QueuePtrWidth = $clog2(QueueDepth);

	// sync thresholds in Q.11 volts
	localparam int SyncHighLevel = 2048;
	localparam int SyncLowLevel  = 0;

	localparam logic [CfgIndexWidth-1:0] REG_INPUT_GAIN      = 2'd0;
	localparam logic [CfgIndexWidth-1:0] REG_INPUT_OFFSET    = 2'd1;
	localparam logic [CfgIndexWidth-1:0] REG_CONVERSION_MODE = 2'd2;
	localparam logic [CfgIndexWidth-1:0] REG_RECTIFY_MODE    = 2'd3;

	localparam logic [ModeWidth-1:0] CONV_UNIPOLAR = 2'd0;
	localparam logic [ModeWidth-1:0] CONV_BIPOLAR  = 2'd1;
	localparam logic [ModeWidth-1:0] CONV_SIGNMAG  = 2'd2;

	localparam logic [ModeWidth-1:0] RECT_NONE = 2'd0;
	localparam logic [ModeWidth-1:0] RECT_HALF = 2'd1;
	localparam logic [ModeWidth-1:0] RECT_FULL = 2'd2;

	localparam logic signed [GainWidth-1:0]   GainReset   = 16'sd3277;
	localparam logic signed [OffsetWidth-1:0] OffsetReset = '0;

	typedef enum logic [1:0] {
		TRIG_UNKNOWN = 2'd0,
		TRIG_LOW     = 2'd1,
		TRIG_HIGH    = 2'd2
	} trig_state_t;

	typedef struct packed {
		logic signed [GainWidth-1:0]   gain;
		logic signed [OffsetWidth-1:0] offset;
		logic [ModeWidth-1:0]          conv_mode;
		logic [ModeWidth-1:0]          rect_mode;
	} cfg_t;

	typedef struct packed {
		logic signed [SampleWidth-1:0] sample;
		logic                          conv;
	} item_t;

endpackage

@@ rtl/core/svq_in_if.sv @@
// input channel: one sample with its sync level and sync-patched flag
// depends on svq_pkg
interface svq_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [svq_pkg::SampleWidth-1:0] sample_in;
	logic signed [svq_pkg::SampleWidth-1:0] sync_level;
	logic                                  sync_connected;

	modport source (output valid, sample_in, sync_level, sync_connected, input ready);
	modport sink (input valid, sample_in, sync_level, sync_connected, output ready);
endinterface

@@ rtl/core/svq_out_if.sv @@
// result channel: held code and conversion flag
// depends on svq_pkg
interface svq_out_if;
	logic                           valid;
	logic                           ready;
	logic [svq_pkg::CodeWidth-1:0]  held_code_out;
	logic                           converted;

	modport source (output valid, held_code_out, converted, input ready);
	modport sink (input valid, held_code_out, converted, output ready);
endinterface

@@ rtl/core/svq_cfg_if.sv @@
// configuration write channel: register index and write data
// depends on svq_pkg
interface svq_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [svq_pkg::CfgIndexWidth-1:0]    index;
	logic [svq_pkg::CfgDataWidth-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/svq_front.sv @@
// front end: takes samples, runs the sync schmitt trigger, marks items to convert
// depends on svq_pkg and svq_in_if
module svq_front (
	input  logic                           clk,
	input  logic                           arst_n,
	svq_in_if.sink                         sample_ch,
	input  logic [svq_pkg::ModeWidth-1:0]  conv_mode,
	output logic                           push_valid,
	input  logic                           push_ready,
	output svq_pkg::item_t                 push_item
);

	svq_pkg::trig_state_t trig_q;
	svq_pkg::trig_state_t trig_next;
	logic                 lvl_high;
	logic                 lvl_low;
	logic                 sync_edge;
	logic                 fire;
	logic                 transfer;

	assign lvl_high = int'(sample_ch.sync_level) >= svq_pkg::SyncHighLevel;
	assign lvl_low  = int'(sample_ch.sync_level) <= svq_pkg::SyncLowLevel;
	assign transfer = sample_ch.valid && sample_ch.ready;

	always_comb begin
		trig_next = trig_q;
		unique case (trig_q)
			svq_pkg::TRIG_LOW: begin
				if (lvl_high) trig_next = svq_pkg::TRIG_HIGH;
			end
			svq_pkg::TRIG_HIGH: begin
				if (lvl_low) trig_next = svq_pkg::TRIG_LOW;
			end
			default: begin
				if (lvl_high)     trig_next = svq_pkg::TRIG_HIGH;
				else if (lvl_low) trig_next = svq_pkg::TRIG_LOW;
				else              trig_next = svq_pkg::TRIG_UNKNOWN;
			end
		endcase
	end

	// only a low-to-high move counts as an edge
	always_comb begin
		sync_edge = (trig_q == svq_pkg::TRIG_LOW) && lvl_high;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q <= svq_pkg::TRIG_UNKNOWN;
		end else if (transfer && sample_ch.sync_connected) begin
			trig_q <= trig_next;
		end
	end

	assign fire = !sample_ch.sync_connected || sync_edge;

	assign push_valid       = sample_ch.valid;
	assign sample_ch.ready  = push_ready;
	assign push_item.sample = sample_ch.sample_in;
	assign push_item.conv   = fire && (conv_mode == svq_pkg::CONV_UNIPOLAR
		|| conv_mode == svq_pkg::CONV_BIPOLAR || conv_mode == svq_pkg::CONV_SIGNMAG);

endmodule

@@ rtl/core/svq_fifo.sv @@
// short queue between front and back ends
// depends on svq_pkg
module svq_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  svq_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output svq_pkg::item_t pop_item
);

	localparam int PtrW = svq_pkg::QueuePtrWidth;

	svq_pkg::item_t  mem_q [svq_pkg::QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [PtrW:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != (PtrW+1)'(svq_pkg::QueueDepth);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(svq_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(svq_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
		end
	end

endmodule

@@ rtl/core/svq_back.sv @@
// back end: scale and offset, rectify, encode to 8 bits, hold the code
// depends on svq_pkg and svq_out_if
module svq_back (
	input  logic           clk,
	input  logic           arst_n,
	input  svq_pkg::cfg_t  cfg,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  svq_pkg::item_t pop_item,
	svq_out_if.source      result_ch
);

	localparam int XW = svq_pkg::XWidth;
	localparam int FB = svq_pkg::FracBits;
	localparam logic signed [XW-1:0] OneX = XW'(1) << FB;

	logic                                    advance;
	logic signed [svq_pkg::ProdWidth-1:0]    prod;
	logic signed [XW-1:0]                    x_next;
	logic signed [XW-1:0]                    x_s1;
	logic                                    conv_s1;
	logic                                    valid_s1;
	logic signed [XW-1:0]                    r;
	logic signed [XW-1:0]                    r_neg;
	logic [FB:0]                             c_uni;
	logic [FB+9:0]                           t_uni;
	logic signed [XW-1:0]                    cl_bip;
	logic [FB+1:0]                           u_bip;
	logic [FB+10:0]                          t_bip;
	logic [FB:0]                             m_sm;
	logic [FB+8:0]                           t_sm;
	logic [svq_pkg::CodeWidth-1:0]           code;
	logic [svq_pkg::CodeWidth-1:0]           held_q;
	logic                                    out_conv_q;
	logic                                    out_valid_q;

	assign advance   = !out_valid_q || result_ch.ready;
	assign pop_ready = advance;

	// stage 1: multiply and add the offset
	assign prod   = pop_item.sample * cfg.gain;
	assign x_next = XW'(prod) + (XW'(cfg.offset) <<< svq_pkg::OffsetShift);

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1    <= x_next;
			conv_s1 <= pop_item.conv;
		end
	end

	// stage 2: rectify and encode
	always_comb begin
		r_neg = -x_s1;
		unique case (cfg.rect_mode)
			svq_pkg::RECT_HALF: r = (x_s1 > 0) ? x_s1 : '0;
			svq_pkg::RECT_FULL: r = (x_s1 < 0) ? r_neg : x_s1;
			default:            r = x_s1;
		endcase
	end

	always_comb begin
		// unipolar: round(clamp(r, 0, 1) * 255)
		if (r < 0)         c_uni = '0;
		else if (r > OneX) c_uni = (FB+1)'(OneX);
		else               c_uni = r[FB:0];
		t_uni = ((FB+10)'(c_uni) << 8) - (FB+10)'(c_uni) + ((FB+10)'(1) << (FB-1));

		// bipolar offset binary: round((clamp(r, -1, 1) + 1) * 255 / 2)
		if (r < -OneX)     cl_bip = -OneX;
		else if (r > OneX) cl_bip = OneX;
		else               cl_bip = r;
		u_bip = (FB+2)'(cl_bip + OneX);
		t_bip = ((FB+11)'(u_bip) << 8) - (FB+11)'(u_bip) + (FB+11)'(OneX);

		// sign magnitude on the clamped magnitude
		if (r < 0) m_sm = ((-r) > OneX) ? (FB+1)'(OneX) : (FB+1)'(-r);
		else       m_sm = (r > OneX) ? (FB+1)'(OneX) : r[FB:0];
		t_sm = ((FB+9)'(m_sm) << 7) - (FB+9)'(m_sm) + ((FB+9)'(1) << (FB-1));

		unique case (cfg.conv_mode)
			svq_pkg::CONV_UNIPOLAR: code = t_uni[FB+7:FB];
			svq_pkg::CONV_BIPOLAR:  code = t_bip[FB+8:FB+1];
			default:                code = {r < 0, t_sm[FB+6:FB]};
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) out_conv_q <= conv_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			held_q      <= '0;
		end else if (advance) begin
			valid_s1    <= pop_valid;
			out_valid_q <= valid_s1;
			if (valid_s1 && conv_s1) held_q <= code;
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.held_code_out = held_q;
	assign result_ch.converted     = out_conv_q;

endmodule

@@ rtl/core/synced_voltage_to_8bit_quantizer.sv @@
// Sample-and-hold 8-bit quantizer with Schmitt-triggered sync. Each accepted sample
// gives exactly one result carrying the held code and a flag that says whether this
// sample was converted. In a defined conversion mode, unpatched sync converts every
// sample; otherwise only a rising sync edge (up at 1 V, down at 0 V) does. One sample
// is accepted per clock cycle, sustained while results are taken; a sample passes the
// queue, the multiply stage register and the output register, and the two-entry queue
// lets input and output stall independently. Configuration writes are taken every
// cycle and should only be made while no sample is in flight.
// Depends on svq_pkg, svq_in_if, svq_out_if, svq_cfg_if, svq_front, svq_fifo, svq_back.
module synced_voltage_to_8bit_quantizer (
	input  logic       clk,
	input  logic       arst_n,
	svq_in_if.sink     sample_ch,
	svq_out_if.source  result_ch,
	svq_cfg_if.sink    cfg_ch
);

	svq_pkg::cfg_t  cfg_q;
	logic           push_valid;
	logic           push_ready;
	svq_pkg::item_t push_item;
	logic           pop_valid;
	logic           pop_ready;
	svq_pkg::item_t pop_item;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain      <= svq_pkg::GainReset;
			cfg_q.offset    <= svq_pkg::OffsetReset;
			cfg_q.conv_mode <= svq_pkg::CONV_UNIPOLAR;
			cfg_q.rect_mode <= svq_pkg::RECT_NONE;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			unique case (cfg_ch.index)
				svq_pkg::REG_INPUT_GAIN:
					cfg_q.gain <= cfg_ch.data[svq_pkg::GainWidth-1:0];
				svq_pkg::REG_INPUT_OFFSET:
					cfg_q.offset <= cfg_ch.data[svq_pkg::OffsetWidth-1:0];
				svq_pkg::REG_CONVERSION_MODE:
					cfg_q.conv_mode <= cfg_ch.data[svq_pkg::ModeWidth-1:0];
				svq_pkg::REG_RECTIFY_MODE:
					cfg_q.rect_mode <= cfg_ch.data[svq_pkg::ModeWidth-1:0];
				default: ;
			endcase
		end
	end

	svq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_ch  (sample_ch),
		.conv_mode  (cfg_q.conv_mode),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	svq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	svq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.result_ch (result_ch)
	);

endmodule

@@ rtl/core/svq_checker.sv @@
// port-level checks for the quantizer, bound to the top level
// depends on svq_pkg and synced_voltage_to_8bit_quantizer_defines.svh
`include "synced_voltage_to_8bit_quantizer_defines.svh"

module svq_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [svq_pkg::CodeWidth-1:0]       held_code_out,
	input logic                                converted,
	input logic                                cfg_valid,
	input logic                                cfg_ready,
	input logic [svq_pkg::CfgIndexWidth-1:0]   cfg_index,
	input logic [svq_pkg::CfgDataWidth-1:0]    cfg_data
);

	logic [svq_pkg::CodeWidth-1:0] last_code_q;
	logic [svq_pkg::ModeWidth-1:0] conv_mode_q;

	// code of the last result transferred out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_code_q <= '0;
		end else if (out_valid && out_ready) begin
			last_code_q <= held_code_out;
		end
	end

	// shadow of the conversion mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_mode_q <= svq_pkg::CONV_UNIPOLAR;
		end else if (cfg_valid && cfg_ready && cfg_index == svq_pkg::REG_CONVERSION_MODE) begin
			conv_mode_q <= cfg_data[svq_pkg::ModeWidth-1:0];
		end
	end

	`SVQ_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(held_code_out) && $stable(converted))
	`SVQ_ASSERT_NOW(a_code_kept, out_valid && !converted, held_code_out == last_code_q)
	`SVQ_ASSERT_NOW(a_mode_valid, out_valid && converted, conv_mode_q <= svq_pkg::CONV_SIGNMAG)

endmodule

bind synced_voltage_to_8bit_quantizer svq_checker u_svq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result_ch.valid),
	.out_ready     (result_ch.ready),
	.held_code_out (result_ch.held_code_out),
	.converted     (result_ch.converted),
	.cfg_valid     (cfg_ch.valid),
	.cfg_ready     (cfg_ch.ready),
	.cfg_index     (cfg_ch.index),
	.cfg_data      (cfg_ch.data)
);

@@ tb/tb.sv @@
// self-checking bench for synced_voltage_to_8bit_quantizer
// predicts the held code per sample with its own sync trigger and config copy
// depends on svq_pkg, svq_in_if, svq_out_if, svq_cfg_if and the quantizer rtl
module tb;
	import svq_pkg::*;

	localparam longint OneQ25 = longint'(1) << FracBits;
	localparam int ItemsPerPhase = 32;
	localparam int NumPhases = 16;
	localparam int LongHold = 64;

	typedef struct {
		logic signed [SampleWidth-1:0] sample;
		logic signed [SampleWidth-1:0] level;
		logic                          conn;
	} sample_item_t;

	typedef struct {
		logic [CodeWidth-1:0] code;
		logic                 converted;
	} quant_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	svq_in_if  sample_ch();
	svq_out_if result_ch();
	svq_cfg_if cfg_ch();

	synced_voltage_to_8bit_quantizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	// predictor state
	logic signed [GainWidth-1:0]   gain_model;
	logic signed [OffsetWidth-1:0] offset_model;
	logic [ModeWidth-1:0]          conv_model;
	logic [ModeWidth-1:0]          rect_model;
	logic [CodeWidth-1:0]          held_model;
	trig_state_t                   trig_model;

	sample_item_t  pending_samples[$];
	quant_result_t expected_codes[$];
	int            items_queued = 0;
	int            items_accepted = 0;
	int            mismatches = 0;
	bit            in_taken = 1'b0;
	int            src_idle_pct = 18;
	int            snk_idle_pct = 83;
	int            hold_reqs = 0;
	int            hold_seen = 0;
	int            hold_left = 0;
	bit            sync_hi = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// schmitt trigger on sync: true only on a low to high transition
	function automatic logic sync_rise(longint lvl);
		case (trig_model)
			TRIG_LOW: begin
				if (lvl >= SyncHighLevel) begin
					trig_model = TRIG_HIGH;
					return 1'b1;
				end
			end
			TRIG_HIGH: begin
				if (lvl <= SyncLowLevel)
					trig_model = TRIG_LOW;
			end
			default: begin
				if (lvl >= SyncHighLevel)
					trig_model = TRIG_HIGH;
				else if (lvl <= SyncLowLevel)
					trig_model = TRIG_LOW;
				else
					trig_model = TRIG_UNKNOWN;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic quant_result_t quantize(sample_item_t it);
		quant_result_t r;
		longint x;
		longint m;
		logic fire;
		fire = !it.conn || sync_rise(longint'(it.level));
		r.converted = 1'b0;
		if (fire) begin
			x = longint'(it.sample) * longint'(gain_model)
				+ (longint'(offset_model) <<< OffsetShift);
			case (rect_model)
				RECT_HALF: x = (x > 0) ? x : 0;
				RECT_FULL: x = (x < 0) ? -x : x;
				default: ;
			endcase
			case (conv_model)
				CONV_UNIPOLAR: begin
					held_model = 8'((clip(x, 0, OneQ25) * 255 + OneQ25 / 2) >> FracBits);
					r.converted = 1'b1;
				end
				CONV_BIPOLAR: begin
					m = clip(x, -OneQ25, OneQ25) + OneQ25;
					held_model = 8'((m * 255 + OneQ25) >> (FracBits + 1));
					r.converted = 1'b1;
				end
				CONV_SIGNMAG: begin
					m = (x < 0) ? -x : x;
					if (m > OneQ25)
						m = OneQ25;
					// sign bit stays set even when the magnitude rounds to zero
					held_model = {x < 0, 7'((m * 127 + OneQ25 / 2) >> FracBits)};
					r.converted = 1'b1;
				end
				default: ;
			endcase
		end
		r.code = held_model;
		return r;
	endfunction

	// sample channel: accept at the rising edge, drive at the falling edge
	always @(posedge clk) begin : sample_accept
		sample_item_t it;
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			it.sample = sample_ch.sample_in;
			it.level = sample_ch.sync_level;
			it.conn = sample_ch.sync_connected;
			expected_codes.push_back(quantize(it));
			items_accepted++;
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin : sample_drive
		sample_item_t nxt;
		if (arst_n && (!sample_ch.valid || in_taken)) begin
			in_taken = 1'b0;
			if (pending_samples.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt = pending_samples.pop_front();
				sample_ch.valid <= 1'b1;
				sample_ch.sample_in <= nxt.sample;
				sample_ch.sync_level <= nxt.level;
				sample_ch.sync_connected <= nxt.conn;
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// result side back-pressure, with an occasional long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = LongHold;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		quant_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_codes.size() == 0) begin
				$error("unexpected transfer: held_code_out %0d converted %0d",
					result_ch.held_code_out, result_ch.converted);
				mismatches++;
			end else begin
				want = expected_codes.pop_front();
				if (result_ch.held_code_out !== want.code) begin
					$error("held_code_out: expected %0d, got %0d",
						want.code, result_ch.held_code_out);
					mismatches++;
				end
				if (result_ch.converted !== want.converted) begin
					$error("converted: expected %0d, got %0d",
						want.converted, result_ch.converted);
					mismatches++;
				end
			end
		end
	end

	task automatic cfg_write(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_INPUT_GAIN:      gain_model = val;
			REG_INPUT_OFFSET:    offset_model = val[OffsetWidth-1:0];
			REG_CONVERSION_MODE: conv_model = val[ModeWidth-1:0];
			REG_RECTIFY_MODE:    rect_model = val[ModeWidth-1:0];
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic push_sample(int smp, int lvl, logic conn);
		sample_item_t it;
		it.sample = SampleWidth'(smp);
		it.level = SampleWidth'(lvl);
		it.conn = conn;
		pending_samples.push_back(it);
		items_queued++;
	endtask

	// mostly hysteresis-shaped sync with random content, some wild levels
	task automatic queue_random_sample();
		int smp;
		int lvl;
		if ($urandom_range(3) == 0)
			smp = int'($urandom);
		else
			smp = int'($urandom_range(20480)) - 10240;
		if ($urandom_range(99) < 45)
			sync_hi = !sync_hi;
		case ($urandom_range(7))
			0: lvl = sync_hi ? SyncHighLevel : SyncLowLevel;
			1: lvl = sync_hi ? int'($urandom_range(32767, 2049)) : -int'($urandom_range(32768, 1));
			2: lvl = int'($urandom_range(2047, 1));
			3: lvl = int'($urandom);
			default: lvl = sync_hi ? int'($urandom_range(12288, 2048)) : -int'($urandom_range(4096));
		endcase
		push_sample(smp, lvl, $urandom_range(99) < 80);
	endtask

	// wait for every sample to be taken and every result checked
	task automatic drain();
		do @(negedge clk); while (items_accepted != items_queued || expected_codes.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int g;
		int o;
		sample_ch.valid = 1'b0;
		sample_ch.sample_in = '0;
		sample_ch.sync_level = '0;
		sample_ch.sync_connected = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		gain_model = GainReset;
		offset_model = OffsetReset;
		conv_model = CONV_UNIPOLAR;
		rect_model = RECT_NONE;
		held_model = '0;
		trig_model = TRIG_UNKNOWN;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: field extremes, then walk the trigger through its states
		push_sample(32767, 0, 1'b0);
		push_sample(-32768, 0, 1'b0);
		push_sample(0, 0, 1'b0);
		push_sample(10240, 0, 1'b0);
		push_sample(5120, 0, 1'b0);
		push_sample(-1, 0, 1'b0);
		push_sample(4096, 1024, 1'b1);
		push_sample(4096, 2048, 1'b1);
		push_sample(4096, 0, 1'b1);
		push_sample(4096, 2047, 1'b1);
		push_sample(8000, 2048, 1'b1);
		push_sample(2000, 32767, 1'b1);
		push_sample(2000, 1, 1'b1);
		push_sample(2000, 0, 1'b1);
		push_sample(2000, -32768, 1'b1);
		// unpatched sync converts and leaves the trigger alone
		push_sample(6000, 2048, 1'b0);
		push_sample(7000, 2048, 1'b1);
		drain();

		cfg_write(REG_CONVERSION_MODE, CfgDataWidth'(CONV_SIGNMAG));
		push_sample(-1, 0, 1'b0);
		push_sample(-32768, 0, 1'b0);
		push_sample(32767, 0, 1'b0);
		drain();

		// unused conversion code: held, nothing converted
		cfg_write(REG_CONVERSION_MODE, CfgDataWidth'(CONV_SIGNMAG | CONV_BIPOLAR));
		push_sample(1000, 0, 1'b0);
		drain();

		cfg_write(REG_CONVERSION_MODE, CfgDataWidth'(CONV_BIPOLAR));
		cfg_write(REG_RECTIFY_MODE, CfgDataWidth'(RECT_FULL));
		push_sample(-10240, 0, 1'b0);
		push_sample(0, 0, 1'b0);
		drain();

		for (int p = 0; p < NumPhases; p++) begin
			if (p == 5) begin
				src_idle_pct = 83;
				snk_idle_pct = 18;
			end else if (p == 10) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			case (p)
				0: g = 16384;
				1: g = -16384;
				2: g = 32767;
				3: g = -32768;
				4: g = 0;
				default: g = int'($urandom_range(32768)) - 16384;
			endcase
			case (p)
				0: o = 10240;
				1: o = -10240;
				2: o = 16383;
				3: o = -16384;
				4, 5: o = 0;
				default: o = ($urandom_range(1) != 0) ? int'($urandom_range(4096)) - 2048
					: int'($urandom_range(20480)) - 10240;
			endcase
			// every conversion code paired with every rectify code over the run
			cfg_write(REG_CONVERSION_MODE, CfgDataWidth'(p % 4));
			cfg_write(REG_RECTIFY_MODE, CfgDataWidth'(p / 4));
			cfg_write(REG_INPUT_GAIN, CfgDataWidth'(g));
			cfg_write(REG_INPUT_OFFSET, CfgDataWidth'(o));
			for (int k = 0; k < ItemsPerPhase; k++)
				queue_random_sample();
			if (p == 10)
				hold_reqs++;
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/svq_pkg.sv
rtl/core/svq_in_if.sv
rtl/core/svq_out_if.sv
rtl/core/svq_cfg_if.sv
rtl/core/svq_front.sv
rtl/core/svq_fifo.sv
rtl/core/svq_back.sv
rtl/core/synced_voltage_to_8bit_quantizer.sv
rtl/core/svq_checker.sv
tb/tb.sv
